// ===== hdl/vec3alu_pkg.sv =====
// Shared types and codes of the three-component fixed-point vector ALU.
// No dependencies; the ALU unit and the testbench import this package.
package vec3alu_pkg;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_ADDSCAL = 4'd2,
      OP_SUBSCAL = 4'd3,
      OP_MULSCAL = 4'd4,
      OP_DIVSCAL = 4'd5,
      OP_MUL     = 4'd6,
      OP_DIV     = 4'd7,
      OP_LEN     = 4'd8,
      OP_NORM    = 4'd9,
      OP_ABS     = 4'd10,
      OP_CLAMP   = 4'd11,
      OP_DOT     = 4'd12
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] scalar_out;
      logic [1:0]         status;
   } rsp_type;

endpackage

// ===== hdl/vec3alu_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Standalone; carries an opaque tag alongside each radicand.
module vec3alu_sqrt #(
   parameter int W     = 32,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [2*W-1:0]   in_rad,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [W-1:0]     out_root,
   output logic [TAG_W-1:0] out_tag
);
   logic             v_ff    [W];
   logic [TAG_W-1:0] tag_ff  [W];
   logic [W+1:0]     rem_ff  [W];
   logic [W-1:0]     root_ff [W];
   logic [2*W-1:0]   rad_ff  [W];

   for (genvar j = 0; j < W; j++) begin : g_stage
      logic             v_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [W+1:0]     rem_prev;
      logic [W-1:0]     root_prev;
      logic [2*W-1:0]   rad_prev;
      logic [W+1:0]     cur;
      logic [W+1:0]     trial;
      logic             ge;
      logic [W+1:0]     rem_in;
      logic [W-1:0]     root_in;
      logic [2*W-1:0]   rad_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign tag_prev  = in_tag;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign tag_prev  = tag_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rad_prev  = rad_ff[j-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      always_comb begin
         cur     = {rem_prev[W-1:0], rad_prev[2*W-1:2*W-2]};
         trial   = {root_prev, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? (cur - trial) : cur;
         root_in = {root_prev[W-2:0], ge};
         rad_in  = rad_prev << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (enable) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            tag_ff[j]  <= tag_prev;
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            rad_ff[j]  <= rad_in;
         end
      end
   end

   assign out_valid = v_ff[W-1];
   assign out_root  = root_ff[W-1];
   assign out_tag   = tag_ff[W-1];

endmodule

// ===== hdl/vec3alu_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Standalone; the caller guarantees the quotient fits W bits or ignores it.
module vec3alu_div #(
   parameter int W     = 32,
   parameter int F     = 16,
   parameter int TAG_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [2:0][W+F-1:0]   in_num,
   input  logic [2:0][W-1:0]     in_den,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [2:0][W-1:0]     out_quo,
   output logic [TAG_W-1:0]      out_tag
);
   logic                v_ff   [W];
   logic [TAG_W-1:0]    tag_ff [W];
   logic [2:0][W:0]     rem_ff [W];
   logic [2:0][W-1:0]   quo_ff [W];
   logic [2:0][W-1:0]   lo_ff  [W];
   logic [2:0][W-1:0]   den_ff [W];

   for (genvar j = 0; j < W; j++) begin : g_stage
      logic              v_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [2:0][W:0]   rem_prev;
      logic [2:0][W-1:0] quo_prev;
      logic [2:0][W-1:0] lo_prev;
      logic [2:0][W-1:0] den_prev;
      logic [2:0][W:0]   cur;
      logic [2:0]        ge;
      logic [2:0][W:0]   rem_in;
      logic [2:0][W-1:0] quo_in;
      logic [2:0][W-1:0] lo_in;

      if (j == 0) begin : g_first
         assign v_prev   = in_valid;
         assign tag_prev = in_tag;
         assign quo_prev = '0;
         assign den_prev = in_den;
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_prev[l] = (W+1)'(in_num[l][W+F-1:W]);
            assign lo_prev[l]  = in_num[l][W-1:0];
         end
      end else begin : g_next
         assign v_prev   = v_ff[j-1];
         assign tag_prev = tag_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign lo_prev  = lo_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            cur[l]    = {rem_prev[l][W-1:0], lo_prev[l][W-1]};
            ge[l]     = (cur[l] >= {1'b0, den_prev[l]});
            rem_in[l] = ge[l] ? (cur[l] - {1'b0, den_prev[l]}) : cur[l];
            quo_in[l] = {quo_prev[l][W-2:0], ge[l]};
            lo_in[l]  = lo_prev[l] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (enable) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            tag_ff[j] <= tag_prev;
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            lo_ff[j]  <= lo_in;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign out_valid = v_ff[W-1];
   assign out_quo   = quo_ff[W-1];
   assign out_tag   = tag_ff[W-1];

endmodule

// ===== hdl/vec3_fixed_point_alu_unit.sv =====
// Three-component signed fixed-point vector ALU. It accepts one item per clock while not
// stalled and returns each result in order; every opcode takes the same path. The pipeline
// depth is dominated by the square-root unit and the divider, each of which resolves one
// result bit per register stage. The whole pipeline stalls only while a finished result
// waits on rsp_ready.
module vec3_fixed_point_alu_unit
   import vec3alu_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);
   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int XW = 2*W + 2;
   localparam logic signed [XW-1:0] VMAX_X = {{(W+3){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] VMIN_X = {{(W+3){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [XW-1:0] HALF_X = XW'(1) << (F-1);

   typedef struct packed {
      logic [3:0]        op;
      logic [2:0][W-1:0] r;
      logic              ov;
      logic [W-1:0]      sc;
      logic [2:0][W-1:0] a;
      logic [2:0][W-1:0] d;
   } mid_type;

   typedef struct packed {
      logic [3:0]        op;
      logic [2:0][W-1:0] r;
      logic              ov;
      logic [W-1:0]      sc;
      logic [2:0]        negq;
      logic [2:0]        dz;
      logic [2:0]        big;
      logic [2:0]        apos;
      logic [2:0]        aneg;
   } post_type;

   localparam int MID_W  = $bits(mid_type);
   localparam int POST_W = $bits(post_type);

   // Saturate to W bits; the top bit of the result flags an overflow.
   function automatic logic [W:0] sat_f(input logic signed [XW-1:0] x);
      logic [W:0] res;
      if (x > VMAX_X) begin
         res = {1'b1, VMAX_X[W-1:0]};
      end else if (x < VMIN_X) begin
         res = {1'b1, VMIN_X[W-1:0]};
      end else begin
         res = {1'b0, x[W-1:0]};
      end
      return res;
   endfunction

   logic    adv;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: input register.
   logic                s1_v_ff;
   logic [3:0]          s1_op_ff;
   logic signed [W-1:0] s1_a_ff [3];
   logic signed [W-1:0] s1_b_ff [3];
   logic signed [W-1:0] s1_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff   <= req_payload.opcode;
         s1_a_ff[0] <= W'(req_payload.a_x);
         s1_a_ff[1] <= W'(req_payload.a_y);
         s1_a_ff[2] <= W'(req_payload.a_z);
         s1_b_ff[0] <= W'(req_payload.b_x);
         s1_b_ff[1] <= W'(req_payload.b_y);
         s1_b_ff[2] <= W'(req_payload.b_z);
         s1_s_ff    <= W'(req_payload.scalar_in);
      end
   end

   // Stage 2: one multiplier per lane, plus the add, subtract, abs and clamp paths.
   logic signed [W-1:0]   s2_m       [3];
   logic signed [2*W-1:0] s2_p_in    [3];
   logic signed [W:0]     s2_simp_in [3];
   logic signed [W-1:0]   s2_d_in    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s1_op_ff == OP_MULSCAL) begin
            s2_m[i] = s1_s_ff;
         end else if (s1_op_ff == OP_LEN || s1_op_ff == OP_NORM) begin
            s2_m[i] = s1_a_ff[i];
         end else begin
            s2_m[i] = s1_b_ff[i];
         end
         s2_p_in[i] = s1_a_ff[i] * s2_m[i];
         s2_d_in[i] = (s1_op_ff == OP_DIVSCAL) ? s1_s_ff : s1_b_ff[i];
         unique case (s1_op_ff)
            OP_ADD:     s2_simp_in[i] = (W+1)'(s1_a_ff[i]) + (W+1)'(s1_b_ff[i]);
            OP_SUB:     s2_simp_in[i] = (W+1)'(s1_a_ff[i]) - (W+1)'(s1_b_ff[i]);
            OP_ADDSCAL: s2_simp_in[i] = (W+1)'(s1_a_ff[i]) + (W+1)'(s1_s_ff);
            OP_SUBSCAL: s2_simp_in[i] = (W+1)'(s1_a_ff[i]) - (W+1)'(s1_s_ff);
            OP_ABS: begin
               s2_simp_in[i] = s1_a_ff[i][W-1] ? -((W+1)'(s1_a_ff[i]))
                                               : (W+1)'(s1_a_ff[i]);
            end
            OP_CLAMP: begin
               s2_simp_in[i] = (s1_a_ff[i] < s1_s_ff) ? (W+1)'(s1_s_ff)
                                                      : (W+1)'(s1_a_ff[i]);
            end
            default:    s2_simp_in[i] = '0;
         endcase
      end
   end

   logic                  s2_v_ff;
   logic [3:0]            s2_op_ff;
   logic signed [W-1:0]   s2_a_ff    [3];
   logic signed [W-1:0]   s2_d_ff    [3];
   logic signed [2*W-1:0] s2_p_ff    [3];
   logic signed [W:0]     s2_simp_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff   <= s1_op_ff;
         s2_a_ff    <= s1_a_ff;
         s2_d_ff    <= s2_d_in;
         s2_p_ff    <= s2_p_in;
         s2_simp_ff <= s2_simp_in;
      end
   end

   // Stage 3: rounding and saturation; the product sum feeds both dot and length.
   logic signed [XW-1:0] s3_psum;
   logic signed [XW-1:0] s3_dot;
   logic signed [XW-1:0] s3_rnd [3];
   logic [W:0]           s3_sat [3];
   logic [W:0]           s3_sat_dot;
   logic [2*W-1:0]       s3_rad_in;
   logic                 s3_is_mul;
   mid_type              s3_mid_in;

   always_comb begin
      s3_psum    = XW'(s2_p_ff[0]) + XW'(s2_p_ff[1]) + XW'(s2_p_ff[2]);
      s3_dot     = (s3_psum + HALF_X) >>> F;
      s3_rad_in  = s3_psum[2*W-1:0];
      s3_is_mul  = (s2_op_ff == OP_MUL) || (s2_op_ff == OP_MULSCAL);
      s3_mid_in.op = s2_op_ff;
      s3_mid_in.ov = 1'b0;
      for (int i = 0; i < 3; i++) begin
         s3_rnd[i] = (XW'(s2_p_ff[i]) + HALF_X) >>> F;
         if (s3_is_mul) begin
            s3_sat[i] = sat_f(s3_rnd[i]);
         end else begin
            s3_sat[i] = sat_f(XW'(s2_simp_ff[i]));
         end
         s3_mid_in.r[i] = s3_sat[i][W-1:0];
         s3_mid_in.ov   = s3_mid_in.ov | s3_sat[i][W];
         s3_mid_in.a[i] = s2_a_ff[i];
         s3_mid_in.d[i] = s2_d_ff[i];
      end
      s3_sat_dot   = sat_f(s3_dot);
      s3_mid_in.sc = '0;
      if (s2_op_ff == OP_DOT) begin
         s3_mid_in.sc = s3_sat_dot[W-1:0];
         s3_mid_in.ov = s3_mid_in.ov | s3_sat_dot[W];
      end
   end

   logic           s3_v_ff;
   logic [2*W-1:0] s3_rad_ff;
   mid_type        s3_mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_rad_ff <= s3_rad_in;
         s3_mid_ff <= s3_mid_in;
      end
   end

   // Square root of the sum of squares; every item rides along.
   logic             sq_v;
   logic [W-1:0]     sq_root;
   logic [MID_W-1:0] sq_tag;
   mid_type          pm;

   vec3alu_sqrt #(
      .W     (W),
      .TAG_W (MID_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s3_v_ff),
      .in_rad    (s3_rad_ff),
      .in_tag    (s3_mid_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   assign pm = mid_type'(sq_tag);

   // Divider setup: magnitudes, quotient sign, zero divisor and quotient range; also the length result.
   logic signed [W-1:0] pr_a    [3];
   logic signed [W:0]   pr_den  [3];
   logic [W-1:0]        pr_amag [3];
   logic [W-1:0]        pr_dmag [3];
   logic [W:0]          pr_len_sat;
   logic [2:0][W+F-1:0] pr_num_in;
   logic [2:0][W-1:0]   pr_den_in;
   post_type            pr_post_in;

   always_comb begin
      pr_post_in.op = pm.op;
      pr_post_in.r  = pm.r;
      pr_post_in.ov = pm.ov;
      pr_post_in.sc = pm.sc;
      pr_len_sat    = sat_f(XW'({1'b0, sq_root}));
      if (pm.op == OP_LEN) begin
         pr_post_in.sc = pr_len_sat[W-1:0];
         pr_post_in.ov = pm.ov | pr_len_sat[W];
      end
      for (int i = 0; i < 3; i++) begin
         pr_a[i] = $signed(pm.a[i]);
         if (pm.op == OP_NORM) begin
            pr_den[i] = {1'b0, sq_root};
         end else begin
            pr_den[i] = (W+1)'($signed(pm.d[i]));
         end
         pr_amag[i] = pr_a[i][W-1] ? -pr_a[i] : pr_a[i];
         pr_dmag[i] = pr_den[i][W] ? W'(-pr_den[i]) : pr_den[i][W-1:0];
         pr_num_in[i] = {pr_amag[i], {F{1'b0}}};
         pr_den_in[i] = pr_dmag[i];
         pr_post_in.dz[i]   = (pr_dmag[i] == '0);
         // The quotient needs more than W bits when the top of the dividend
         // already reaches the divisor.
         pr_post_in.big[i]  = ((pr_amag[i] >> (W - F)) >= pr_dmag[i]);
         pr_post_in.negq[i] = pr_a[i][W-1] ^ pr_den[i][W];
         pr_post_in.aneg[i] = pr_a[i][W-1];
         pr_post_in.apos[i] = !pr_a[i][W-1] && (pr_a[i] != '0);
      end
   end

   logic                pr_v_ff;
   logic [2:0][W+F-1:0] pr_num_ff;
   logic [2:0][W-1:0]   pr_den_ff;
   post_type            pr_post_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else if (adv) begin
         pr_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_num_ff  <= pr_num_in;
         pr_den_ff  <= pr_den_in;
         pr_post_ff <= pr_post_in;
      end
   end

   logic              dv_v;
   logic [2:0][W-1:0] dv_quo;
   logic [POST_W-1:0] dv_tag;
   post_type          fp;

   vec3alu_div #(
      .W     (W),
      .F     (F),
      .TAG_W (POST_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (pr_v_ff),
      .in_num    (pr_num_ff),
      .in_den    (pr_den_ff),
      .in_tag    (pr_post_ff),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   assign fp = post_type'(dv_tag);

   // Final stage: sign and saturate the quotients, then merge the status.
   logic [W-1:0] fin_r [3];
   logic         fin_ov;
   logic         dz_any;
   logic         dv_is_div;
   logic [1:0]   fin_status;

   always_comb begin
      dv_is_div = (fp.op == OP_DIVSCAL) || (fp.op == OP_DIV) || (fp.op == OP_NORM);
      fin_ov    = fp.ov;
      dz_any    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (!dv_is_div) begin
            fin_r[i] = fp.r[i];
         end else if (fp.dz[i]) begin
            dz_any = 1'b1;
            if (fp.apos[i]) begin
               fin_r[i] = VMAX_X[W-1:0];
            end else if (fp.aneg[i]) begin
               fin_r[i] = VMIN_X[W-1:0];
            end else begin
               fin_r[i] = '0;
            end
         end else if (fp.big[i]) begin
            fin_ov   = 1'b1;
            fin_r[i] = fp.negq[i] ? VMIN_X[W-1:0] : VMAX_X[W-1:0];
         end else if (fp.negq[i]) begin
            if (dv_quo[i] > VMIN_X[W-1:0]) begin
               fin_ov   = 1'b1;
               fin_r[i] = VMIN_X[W-1:0];
            end else begin
               fin_r[i] = -dv_quo[i];
            end
         end else if (dv_quo[i] > VMAX_X[W-1:0]) begin
            fin_ov   = 1'b1;
            fin_r[i] = VMAX_X[W-1:0];
         end else begin
            fin_r[i] = dv_quo[i];
         end
      end
      if (dz_any) begin
         fin_status = ST_DIV_ZERO;
      end else if (fin_ov) begin
         fin_status = ST_OVERFLOW;
      end else begin
         fin_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.r_x        <= 32'(signed'(fin_r[0]));
         rsp_ff.r_y        <= 32'(signed'(fin_r[1]));
         rsp_ff.r_z        <= 32'(signed'(fin_r[2]));
         rsp_ff.scalar_out <= 32'(signed'(fp.sc));
         rsp_ff.status     <= fin_status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A zero divide can only come out of the divide and normalize operations.
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      dv_v && !dv_is_div |-> !dz_any)
      else $error("divide-by-zero flagged on a non-divide operation");

   // Length operations must not carry vector results from the front end.
   a_len_r_zero: assert property (@(posedge clock) disable iff (reset)
      sq_v && (pm.op == OP_LEN || pm.op == OP_NORM) |-> pm.r == '0)
      else $error("vector result leaked into a length operation");

   // The root lines up with its item: a zero length only for a zero vector.
   a_root_aligned: assert property (@(posedge clock) disable iff (reset)
      sq_v && pm.op == OP_NORM && sq_root == '0 |-> pm.a == '0)
      else $error("square root misaligned with its item");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the three-component fixed-point vector ALU.
// Depends on vec3alu_pkg and vec3_fixed_point_alu_unit; predicts each result in place.
`timescale 1ns / 1ps

module testbench;
   import vec3alu_pkg::*;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam longint ONE = 64'sd65536;
   localparam longint HALF = 64'sd32768;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type pending_ops[$];
   rsp_type expected_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   vec3_fixed_point_alu_unit dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint saturate(input longint x, inout bit ov);
      if (x > VMAX) begin
         ov = 1'b1;
         return VMAX;
      end
      if (x < VMIN) begin
         ov = 1'b1;
         return VMIN;
      end
      return x;
   endfunction

   // Arithmetic shift is a floor division by the fraction scale.
   function automatic longint fx_mul(input longint a, input longint b, inout bit ov);
      return saturate((a * b + HALF) >>> 16, ov);
   endfunction

   function automatic longint fx_div(input longint a, input longint b, inout bit ov,
                                     inout bit dz);
      if (b == 0) begin
         dz = 1'b1;
         return a > 0 ? VMAX : (a < 0 ? VMIN : 0);
      end
      return saturate((a * ONE) / b, ov);
   endfunction

   function automatic longint int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic rsp_type alu_result(input req_type q);
      longint a[3], b[3], r[3], s, sc, len, hs, ls, p, h;
      logic [63:0] sumsq;
      bit ov, dz;
      rsp_type o;
      a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
      b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
      s = q.scalar_in;
      r[0] = 0; r[1] = 0; r[2] = 0;
      sc = 0; ov = 0; dz = 0; hs = 0; ls = 0; sumsq = 0;
      case (q.opcode)
         OP_ADD: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] + b[i], ov);
         OP_SUB: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] - b[i], ov);
         OP_ADDSCAL: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] + s, ov);
         OP_SUBSCAL: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] - s, ov);
         OP_MULSCAL: for (int i = 0; i < 3; i++) r[i] = fx_mul(a[i], s, ov);
         OP_DIVSCAL: for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], s, ov, dz);
         OP_MUL: for (int i = 0; i < 3; i++) r[i] = fx_mul(a[i], b[i], ov);
         OP_DIV: for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], b[i], ov, dz);
         OP_LEN, OP_NORM: begin
            for (int i = 0; i < 3; i++) sumsq += 64'(a[i] * a[i]);
            len = int_sqrt(sumsq);
            if (q.opcode == OP_LEN) sc = saturate(len, ov);
            else if (len == 0) dz = 1'b1;
            else for (int i = 0; i < 3; i++) r[i] = saturate((a[i] * ONE) / len, ov);
         end
         OP_ABS: for (int i = 0; i < 3; i++) r[i] = saturate(a[i] < 0 ? -a[i] : a[i], ov);
         OP_CLAMP: for (int i = 0; i < 3; i++) r[i] = a[i] < s ? s : a[i];
         OP_DOT: begin
            // Split each product so the three can be summed without overflow.
            for (int i = 0; i < 3; i++) begin
               p = a[i] * b[i];
               h = p >>> 16;
               hs += h;
               ls += p - h * ONE;
            end
            sc = saturate(hs + ((ls + HALF) >>> 16), ov);
         end
         default: ;
      endcase
      o.r_x = r[0][31:0];
      o.r_y = r[1][31:0];
      o.r_z = r[2][31:0];
      o.scalar_out = sc[31:0];
      o.status = dz ? ST_DIV_ZERO : (ov ? ST_OVERFLOW : ST_OK);
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
         4: return 32'($signed($urandom_range(0, 512)) - 256);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(input logic [3:0] op, input logic [31:0] ax, ay, az,
                           input logic [31:0] bx, by, bz, sv);
      req_type q;
      q.opcode = op;
      q.a_x = ax; q.a_y = ay; q.a_z = az;
      q.b_x = bx; q.b_y = by; q.b_z = bz;
      q.scalar_in = sv;
      pending_ops.push_back(q);
   endtask

   initial begin
      logic [31:0] mx, mn, o1;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      o1 = 32'h00010000;
      queue_op(OP_ADD, mx, mn, 1, 1, mn, 0, 0);
      queue_op(OP_SUB, mn, mx, 5, 1, 1, 5, 0);
      queue_op(OP_ADDSCAL, mx, mn, 0, 0, 0, 0, mx);
      queue_op(OP_SUBSCAL, mn, mx, 0, 0, 0, 0, mn);
      queue_op(OP_MULSCAL, mx, mn, o1, 0, 0, 0, mx);
      queue_op(OP_MULSCAL, 32'h00000001, 32'hffffffff, 32'h00008000, 0, 0, 0, 32'h00008000);
      queue_op(OP_DIVSCAL, 5, 32'hfffffffb, 0, 0, 0, 0, 0);
      queue_op(OP_DIVSCAL, mx, mn, o1, 0, 0, 0, 1);
      queue_op(OP_MUL, mx, mn, mn, mx, mn, 32'hffffffff, 0);
      queue_op(OP_DIV, mx, o1, 0, 0, 3, 0, 0);
      queue_op(OP_DIV, mn, 7, 32'hfffffff9, 32'hffffffff, 2, 3, 0);
      queue_op(OP_LEN, mn, mn, mn, 0, 0, 0, 0);
      queue_op(OP_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
      queue_op(OP_NORM, 0, 0, 0, 0, 0, 0, 0);
      queue_op(OP_NORM, 1, 0, 0, 0, 0, 0, 0);
      queue_op(OP_NORM, mx, mn, 3, 0, 0, 0, 0);
      queue_op(OP_ABS, mn, mx, 32'hffffffff, 0, 0, 0, 0);
      queue_op(OP_CLAMP, mn, mx, 0, 0, 0, 0, 1);
      queue_op(OP_DOT, mx, mx, mx, mx, mx, mx, 0);
      queue_op(OP_DOT, mn, mn, mn, mn, mn, mn, 0);
      queue_op(OP_DOT, mn, mx, 1, mx, mx, 32'h00008000, 0);
      queue_op(4'd13, mx, mx, mx, mx, mx, mx, mx);
      queue_op(4'd15, mn, 1, 2, 3, 4, 5, 6);
      for (int n = 0; n < 950; n++) begin
         queue_op($urandom_range(0, 99) < 4 ? 4'($urandom_range(13, 15))
                                            : 4'($urandom_range(0, 12)),
                  pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value(),
                  $urandom_range(0, 9) == 0 ? 32'h0 : pick_value());
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_ops.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (150) @(posedge clock);
      stimulus_done = 1'b1;
   end

   // Driver: a new transfer is only offered after the previous one was accepted.
   // Acceptance is taken from the rising edge, since req_ready may change after it.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_ops.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= pending_ops.pop_front();
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap <= pick_gap();
         end
      end
   end

   // Predict at the input transfer and check at the output transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) expected_results.push_back(alu_result(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_payload);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected x=%h y=%h z=%h s=%h st=%0d, got x=%h y=%h z=%h s=%h st=%0d",
                              want.r_x, want.r_y, want.r_z, want.scalar_out, want.status,
                              rsp_payload.r_x, rsp_payload.r_y, rsp_payload.r_z,
                              rsp_payload.scalar_out, rsp_payload.status);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (stimulus_done) begin
            if (mismatches == 0 && expected_results.size() == 0) $display("tb: success");
            else $display("tb: failure");
            $finish;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
hdl/vec3alu_pkg.sv
hdl/vec3alu_sqrt.sv
hdl/vec3alu_div.sv
hdl/vec3_fixed_point_alu_unit.sv
dv/testbench.sv
